// File: rtl/core/srs_pkg.sv
// Shared constants and types for the sliced reservoir sampler.
`default_nettype none

package srs_pkg;

	// Limits of the sample store and the producer set
	localparam int unsigned MAX_SLOTS     = 1048576;
	localparam int unsigned MAX_PRODUCERS = 64;

	// Field widths
	localparam int unsigned CAP_W   = 21;
	localparam int unsigned SLOT_W  = 20;
	localparam int unsigned TC_W    = 7;
	localparam int unsigned PID_W   = 6;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned FRAC_W  = 24;
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned CFG_W   = CAP_W;

	// Counter and datapath widths
	localparam int unsigned CNT_W   = 48;
	localparam int unsigned N_W     = CNT_W + 1;
	localparam int unsigned ACC_W   = N_W + FRAC_W;
	localparam int unsigned LOOP_W  = $clog2(WORD_W);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_CAPACITY     = 1'b0,
		REG_THREAD_COUNT = 1'b1
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_DLOAD,
		ST_DIV,
		ST_IDLE,
		ST_SLICE,
		ST_LEN,
		ST_STEP,
		ST_DECIDE,
		ST_CALC,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// File: rtl/core/srs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module srs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable, read every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// File: rtl/core/sliced_reservoir_sampler.sv
// Sliced reservoir sampler: store decision and slot for each batch element request.
// An accepted request passes ST_SLICE, ST_LEN, ST_STEP, ST_DECIDE, then ST_CALC if a random
// draw is needed (the 64-step radix-2 remainder of rand_word by the slice size), then ST_DONE.
// Requests are taken one at a time; a waiting result does not block acceptance of the next one.
// Reset and each config write run a capacity/thread_count divide with in_ready low.
`default_nettype none

module sliced_reservoir_sampler (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration
	input  wire logic                          cfg_write_en,
	input  wire logic [0:0]                    cfg_index,
	input  wire logic [srs_pkg::CFG_W-1:0]     cfg_data,
	// Request channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [srs_pkg::PID_W-1:0]     producer_id,
	input  wire logic [srs_pkg::LEN_W-1:0]     batch_length,
	input  wire logic                          first_in_batch,
	input  wire logic [srs_pkg::FRAC_W-1:0]    rand_frac,
	input  wire logic [srs_pkg::WORD_W-1:0]    rand_word,
	// Result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               write_enable,
	output logic      [srs_pkg::SLOT_W-1:0]    slot_index,
	output logic      [srs_pkg::LEN_W-1:0]     batch_position,
	output logic      [srs_pkg::CAP_W-1:0]     filled_count
);

	srs_pkg::state_t state_q, state_d;

	// Configuration
	logic [srs_pkg::CAP_W-1:0] cap_q, cap_eff;
	logic [srs_pkg::TC_W-1:0]  tc_q, tc_eff;

	// Slice base divider (quotient shifts in as the dividend shifts out)
	logic [srs_pkg::CAP_W-1:0] divq_q;
	logic [srs_pkg::TC_W-1:0]  drem_q;
	logic [srs_pkg::TC_W:0]    dtrial;
	logic                      dge;

	logic [srs_pkg::LOOP_W-1:0] cnt_q;

	// Captured request
	logic [srs_pkg::PID_W-1:0]  pid_q;
	logic [srs_pkg::LEN_W-1:0]  blen_q;
	logic                       first_q;
	logic [srs_pkg::FRAC_W-1:0] rf_sh_q;
	logic [srs_pkg::WORD_W-1:0] rw_sh_q;

	// Slice geometry
	logic [srs_pkg::PID_W+srs_pkg::CAP_W-1:0] start_full;
	logic [srs_pkg::CAP_W-1:0] start_q, sl_q;
	logic                      pid_ok, pid_last;

	// Batch state
	logic [srs_pkg::CNT_W-1:0] total_q, bbase_q, lbase_q;
	logic                      fill_q, open_q;
	logic [srs_pkg::LEN_W-1:0] eidx_q;
	logic [srs_pkg::MAX_PRODUCERS-1:0] pvalid_q;

	// Producer counter store
	logic                      ram_we;
	logic [srs_pkg::PID_W-1:0] ram_raddr;
	logic [srs_pkg::CNT_W-1:0] ram_rdata;

	logic [srs_pkg::CNT_W-1:0] ps_cur, ps_sat, tot_sat;
	logic [srs_pkg::N_W-1:0]   ps_sum, tot_sum;
	logic                      batch_new, fill_new, own_cnt;

	// Element decision
	logic                      in_rng, pos_ok, samp_next;
	logic [srs_pkg::N_W-1:0]   pos, n_next, n_q;
	logic                      samp_q, fwe_q;
	logic [srs_pkg::SLOT_W-1:0] fslot_q;
	logic [srs_pkg::LEN_W-1:0] bpos_q;
	logic [srs_pkg::CAP_W-1:0] filled_q;

	// Serial acceptance product and slot remainder
	logic [srs_pkg::ACC_W-1:0] acc_q, acc_next, acc_part, thr;
	logic [srs_pkg::CAP_W-1:0] rem_q, rem_next;
	logic [srs_pkg::CAP_W:0]   rtrial, rsub;
	logic                      rge;

	// Final result
	logic                      hit, fin_we, out_free, load_out;
	logic [srs_pkg::CAP_W-1:0] slot_sum;
	logic [srs_pkg::SLOT_W-1:0] fin_slot;

	logic                      out_valid_q, we_out_q;
	logic [srs_pkg::SLOT_W-1:0] slot_out_q;
	logic [srs_pkg::LEN_W-1:0] bpos_out_q;
	logic [srs_pkg::CAP_W-1:0] filled_out_q;

	// Clamp configuration to the supported ranges
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = srs_pkg::CAP_W'(1);
		end else if (cap_q > srs_pkg::CAP_W'(srs_pkg::MAX_SLOTS)) begin
			cap_eff = srs_pkg::CAP_W'(srs_pkg::MAX_SLOTS);
		end else begin
			cap_eff = cap_q;
		end
		if (tc_q == '0) begin
			tc_eff = srs_pkg::TC_W'(1);
		end else if (tc_q > srs_pkg::TC_W'(srs_pkg::MAX_PRODUCERS)) begin
			tc_eff = srs_pkg::TC_W'(srs_pkg::MAX_PRODUCERS);
		end else begin
			tc_eff = tc_q;
		end
	end

	// Restoring divide step for the slice base
	assign dtrial = {drem_q, divq_q[srs_pkg::CAP_W-1]};
	assign dge    = dtrial >= {1'b0, tc_eff};

	// Slice geometry of the current producer
	assign pid_ok     = {1'b0, pid_q} < tc_eff;
	assign pid_last   = {1'b0, pid_q} == (tc_eff - srs_pkg::TC_W'(1));
	assign start_full = (srs_pkg::PID_W + srs_pkg::CAP_W)'(pid_q)
		* (srs_pkg::PID_W + srs_pkg::CAP_W)'(divq_q);

	// Producer counter: an entry not written since reload reads as its slice size
	assign ram_raddr = (state_q == srs_pkg::ST_IDLE) ? producer_id : pid_q;
	assign ps_cur    = pvalid_q[pid_q] ? ram_rdata : srs_pkg::CNT_W'(sl_q);
	assign ps_sum    = {1'b0, ps_cur} + srs_pkg::N_W'(blen_q);
	assign ps_sat    = ps_sum[srs_pkg::CNT_W] ? srs_pkg::CNT_MAX : ps_sum[srs_pkg::CNT_W-1:0];
	assign tot_sum   = {1'b0, total_q} + srs_pkg::N_W'(blen_q);
	assign tot_sat   = tot_sum[srs_pkg::CNT_W] ? srs_pkg::CNT_MAX : tot_sum[srs_pkg::CNT_W-1:0];

	assign batch_new = first_q && (blen_q != '0);
	assign fill_new  = total_q < srs_pkg::CNT_W'(cap_eff);
	assign own_cnt   = !fill_new && pid_ok;
	assign ram_we    = (state_q == srs_pkg::ST_STEP) && batch_new && own_cnt;

	// Element decision inputs
	assign in_rng    = open_q && (eidx_q < blen_q);
	assign pos       = srs_pkg::N_W'(bbase_q) + srs_pkg::N_W'(eidx_q);
	assign pos_ok    = pos < srs_pkg::N_W'(cap_eff);
	assign n_next    = srs_pkg::N_W'(lbase_q) + srs_pkg::N_W'(eidx_q) + srs_pkg::N_W'(1);
	assign samp_next = in_rng && !fill_q && pid_ok && (sl_q != '0);

	// One multiplier bit per cycle in the first FRAC_W ST_CALC steps, one remainder bit per ST_CALC cycle
	assign acc_part = rf_sh_q[srs_pkg::FRAC_W-1] ? srs_pkg::ACC_W'(n_q) : '0;
	assign acc_next = {acc_q[srs_pkg::ACC_W-2:0], 1'b0} + acc_part;
	assign rtrial   = {rem_q, rw_sh_q[srs_pkg::WORD_W-1]};
	assign rge      = rtrial >= {1'b0, sl_q};
	assign rsub     = rtrial - {1'b0, sl_q};
	assign rem_next = rge ? rsub[srs_pkg::CAP_W-1:0] : rtrial[srs_pkg::CAP_W-1:0];

	// Accept when rand_frac * n stays below slice size * 2^24
	assign thr      = srs_pkg::ACC_W'({sl_q, srs_pkg::FRAC_W'(0)});
	assign hit      = acc_q < thr;
	assign slot_sum = start_q + rem_q;
	assign fin_we   = samp_q ? hit : fwe_q;
	assign fin_slot = samp_q ? (hit ? slot_sum[srs_pkg::SLOT_W-1:0] : '0) : fslot_q;
	assign out_free = !out_valid_q || out_ready;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srs_pkg::ST_DLOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			srs_pkg::ST_DLOAD: begin
				state_d = srs_pkg::ST_DIV;
			end
			srs_pkg::ST_DIV: begin
				if (cnt_q == srs_pkg::LOOP_W'(srs_pkg::CAP_W - 1)) begin
					state_d = srs_pkg::ST_IDLE;
				end
			end
			srs_pkg::ST_IDLE: begin
				in_ready = !cfg_write_en;
				if (in_valid && !cfg_write_en) begin
					state_d = srs_pkg::ST_SLICE;
				end
			end
			srs_pkg::ST_SLICE: begin
				state_d = srs_pkg::ST_LEN;
			end
			srs_pkg::ST_LEN: begin
				state_d = srs_pkg::ST_STEP;
			end
			srs_pkg::ST_STEP: begin
				state_d = srs_pkg::ST_DECIDE;
			end
			srs_pkg::ST_DECIDE: begin
				state_d = samp_next ? srs_pkg::ST_CALC : srs_pkg::ST_DONE;
			end
			srs_pkg::ST_CALC: begin
				if (cnt_q == srs_pkg::LOOP_W'(srs_pkg::WORD_W - 1)) begin
					state_d = srs_pkg::ST_DONE;
				end
			end
			srs_pkg::ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = srs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srs_pkg::ST_DLOAD;
			end
		endcase
		// Restart the slice base divide on any config write
		if (cfg_write_en) begin
			state_d = srs_pkg::ST_DLOAD;
		end
	end

	// Control state: configuration, batch counters, valid bits, loop count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= srs_pkg::CAP_W'(srs_pkg::MAX_SLOTS);
			tc_q        <= srs_pkg::TC_W'(1);
			total_q     <= '0;
			bbase_q     <= '0;
			lbase_q     <= '0;
			fill_q      <= 1'b0;
			open_q      <= 1'b0;
			eidx_q      <= '0;
			pvalid_q    <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Write a register, reload producer counters, close the batch
			if (cfg_write_en) begin
				unique case (cfg_index)
					srs_pkg::REG_CAPACITY:     cap_q <= cfg_data;
					srs_pkg::REG_THREAD_COUNT: tc_q  <= cfg_data[srs_pkg::TC_W-1:0];
					default: ;
				endcase
				pvalid_q <= '0;
				open_q   <= 1'b0;
			end

			// Advance the batch state for the captured element
			if (state_q == srs_pkg::ST_STEP) begin
				if (first_q) begin
					eidx_q <= '0;
					if (blen_q == '0) begin
						open_q <= 1'b0;
					end else begin
						open_q  <= 1'b1;
						bbase_q <= total_q;
						total_q <= tot_sat;
						fill_q  <= fill_new;
						lbase_q <= own_cnt ? ps_cur : '0;
					end
				end else if (open_q && (eidx_q != {srs_pkg::LEN_W{1'b1}})) begin
					eidx_q <= eidx_q + srs_pkg::LEN_W'(1);
				end
				if (ram_we) begin
					pvalid_q[pid_q] <= 1'b1;
				end
			end

			// Step the shared loop counter
			case (state_q)
				srs_pkg::ST_DLOAD, srs_pkg::ST_DECIDE: cnt_q <= '0;
				srs_pkg::ST_DIV, srs_pkg::ST_CALC:     cnt_q <= cnt_q + srs_pkg::LOOP_W'(1);
				default: ;
			endcase

			// Hold the result until taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			srs_pkg::ST_DLOAD: begin
				divq_q <= cap_eff;
				drem_q <= '0;
			end
			srs_pkg::ST_DIV: begin
				drem_q <= dge ? srs_pkg::TC_W'(dtrial - {1'b0, tc_eff})
					: dtrial[srs_pkg::TC_W-1:0];
				divq_q <= {divq_q[srs_pkg::CAP_W-2:0], dge};
			end
			srs_pkg::ST_IDLE: begin
				pid_q   <= producer_id;
				blen_q  <= batch_length;
				first_q <= first_in_batch;
				rf_sh_q <= rand_frac;
				rw_sh_q <= rand_word;
			end
			srs_pkg::ST_SLICE: begin
				start_q <= start_full[srs_pkg::CAP_W-1:0];
			end
			srs_pkg::ST_LEN: begin
				sl_q <= pid_last ? (cap_eff - start_q) : divq_q;
			end
			srs_pkg::ST_DECIDE: begin
				n_q      <= n_next;
				samp_q   <= samp_next;
				fwe_q    <= in_rng && fill_q && pos_ok;
				fslot_q  <= (in_rng && fill_q && pos_ok) ? pos[srs_pkg::SLOT_W-1:0] : '0;
				bpos_q   <= open_q ? eidx_q : '0;
				filled_q <= (total_q < srs_pkg::CNT_W'(cap_eff))
					? total_q[srs_pkg::CAP_W-1:0] : cap_eff;
				acc_q    <= '0;
				rem_q    <= '0;
			end
			srs_pkg::ST_CALC: begin
				if (cnt_q < srs_pkg::LOOP_W'(srs_pkg::FRAC_W)) begin
					acc_q   <= acc_next;
					rf_sh_q <= {rf_sh_q[srs_pkg::FRAC_W-2:0], 1'b0};
				end
				rem_q   <= rem_next;
				rw_sh_q <= {rw_sh_q[srs_pkg::WORD_W-2:0], 1'b0};
			end
			default: ;
		endcase

		// Load the output register
		if (load_out) begin
			we_out_q     <= fin_we;
			slot_out_q   <= fin_slot;
			bpos_out_q   <= bpos_q;
			filled_out_q <= filled_q;
		end
	end

	srs_ram #(
		.WIDTH (srs_pkg::CNT_W),
		.DEPTH (srs_pkg::MAX_PRODUCERS)
	) u_ps_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (pid_q),
		.wr_data (ps_sat),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign out_valid      = out_valid_q;
	assign write_enable   = we_out_q;
	assign slot_index     = slot_out_q;
	assign batch_position = bpos_out_q;
	assign filled_count   = filled_out_q;

endmodule

`default_nettype wire

// File: bench/sliced_reservoir_sampler_test.sv
`timescale 1ns / 1ps
// Testbench for sliced_reservoir_sampler: slot decision scoreboard, request driver and result sink.
module sliced_reservoir_sampler_test;
	import srs_pkg::*;

	localparam int unsigned STALL_LIMIT   = 3000;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned CONFIG_GAP    = 80;
	localparam int unsigned DRAIN_CYCLES  = 100;
	localparam int unsigned RANDOM_PHASES = 12;
	localparam int unsigned PHASE_ITEMS   = 60;
	localparam int unsigned FILL_MARGIN   = 20;
	localparam int unsigned SAT_FOLLOWERS = 40;
	localparam int unsigned REPORT_LIMIT  = 200;
	localparam bit [63:0]   COUNT_CEIL    = 64'h0000_FFFF_FFFF_FFFF;

	typedef struct {
		bit                stored;
		bit [SLOT_W-1:0]   slot;
		bit [LEN_W-1:0]    position;
		bit [CAP_W-1:0]    filled;
	} decision_t;

	// Slot decision scoreboard: tracks sampler state and queues the expected decisions
	class slot_decision_board;
		bit [CAP_W-1:0] capacity_reg;
		bit [TC_W-1:0]  threads_reg;
		bit [63:0]      seen_total;
		bit [63:0]      batch_start;
		bit [63:0]      local_start;
		bit [63:0]      producer_seen [MAX_PRODUCERS];
		bit             in_fill;
		bit             batch_active;
		bit [LEN_W-1:0] element_idx;
		decision_t      expected_decisions [$];
		int unsigned    errors;

		function new();
			capacity_reg = MAX_SLOTS;
			threads_reg = 1;
			reload_counters();
		endfunction

		function bit [63:0] capacity_in_use();
			if (capacity_reg == 0) return 1;
			if (capacity_reg > MAX_SLOTS) return MAX_SLOTS;
			return capacity_reg;
		endfunction

		function bit [63:0] threads_in_use();
			if (threads_reg == 0) return 1;
			if (threads_reg > MAX_PRODUCERS) return MAX_PRODUCERS;
			return threads_reg;
		endfunction

		function bit [63:0] add_capped(bit [63:0] a, bit [63:0] b);
			bit [63:0] s;
			s = a + b;
			return (s > COUNT_CEIL) ? COUNT_CEIL : s;
		endfunction

		// Last producer's slice also takes the remainder of the division
		function bit [63:0] slice_size(bit [63:0] p, bit [63:0] cap, bit [63:0] tc,
				output bit [63:0] start);
			bit [63:0] base;
			base = cap / tc;
			start = p * base;
			return (p == tc - 1) ? cap - start : base;
		endfunction

		function void reload_counters();
			bit [63:0] cap, tc, st;
			cap = capacity_in_use();
			tc = threads_in_use();
			for (int i = 0; i < MAX_PRODUCERS; i++) begin
				if (i < tc) begin
					producer_seen[i] = slice_size(i, cap, tc, st);
				end else begin
					producer_seen[i] = 0;
				end
			end
		endfunction

		// Any register write reloads the per-producer counters and closes the batch
		function void write_register(reg_idx_t idx, bit [CFG_W-1:0] value);
			if (idx == REG_CAPACITY) begin
				capacity_reg = value;
			end else begin
				threads_reg = value[TC_W-1:0];
			end
			reload_counters();
			batch_active = 0;
		endfunction

		function void note_request(bit [PID_W-1:0] pid, bit [LEN_W-1:0] blen, bit first,
				bit [FRAC_W-1:0] frac, bit [WORD_W-1:0] word);
			decision_t d;
			bit [63:0] cap, tc, sl, start, n, thr, fill_pos, slot;
			bit        take;
			cap = capacity_in_use();
			tc = threads_in_use();
			d = '{default: 0};
			// Open a batch: claim stream positions and pick fill or sampling
			if (first) begin
				element_idx = 0;
				if (blen == 0) begin
					batch_active = 0;
				end else begin
					batch_active = 1;
					batch_start = seen_total;
					seen_total = add_capped(seen_total, blen);
					in_fill = batch_start < cap;
					local_start = 0;
					if (!in_fill && pid < tc) begin
						local_start = producer_seen[pid];
						producer_seen[pid] = add_capped(producer_seen[pid], blen);
					end
				end
			end else if (batch_active && element_idx != {LEN_W{1'b1}}) begin
				element_idx++;
			end
			// Decide store and slot for this element
			if (batch_active) begin
				d.position = element_idx;
				if (element_idx < blen) begin
					if (in_fill) begin
						fill_pos = batch_start + element_idx;
						if (fill_pos < cap) begin
							d.stored = 1;
							d.slot = fill_pos[SLOT_W-1:0];
						end
					end else if (pid < tc) begin
						sl = slice_size(pid, cap, tc, start);
						n = local_start + element_idx + 1;
						if (sl > 0) begin
							thr = sl << FRAC_W;
							if (frac == 0) begin
								take = 1;
							end else begin
								take = n <= (thr - 1) / frac;
							end
							if (take) begin
								slot = start + word % sl;
								d.stored = 1;
								d.slot = slot[SLOT_W-1:0];
							end
						end
					end
				end
			end
			d.filled = (seen_total < cap) ? seen_total[CAP_W-1:0] : cap[CAP_W-1:0];
			expected_decisions.push_back(d);
		endfunction

		function void report(string field, bit [63:0] want, logic [63:0] got);
			errors++;
			if (errors <= REPORT_LIMIT)
				$error("%s mismatch: expected %0d, actual %0d", field, want, got);
		endfunction

		function void check_decision(logic stored, logic [SLOT_W-1:0] slot,
				logic [LEN_W-1:0] position, logic [CAP_W-1:0] filled);
			decision_t want;
			if (expected_decisions.size() == 0) begin
				errors++;
				$error("result accepted with no request pending");
				return;
			end
			want = expected_decisions.pop_front();
			if (stored !== want.stored) report("write_enable", want.stored, stored);
			if (slot !== want.slot) report("slot_index", want.slot, slot);
			if (position !== want.position) report("batch_position", want.position, position);
			if (filled !== want.filled) report("filled_count", want.filled, filled);
		endfunction

		function int pending();
			return expected_decisions.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write_en = 1'b0;
	logic [0:0]         cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [PID_W-1:0]   producer_id = '0;
	logic [LEN_W-1:0]   batch_length = '0;
	logic               first_in_batch = 1'b0;
	logic [FRAC_W-1:0]  rand_frac = '0;
	logic [WORD_W-1:0]  rand_word = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               write_enable;
	logic [SLOT_W-1:0]  slot_index;
	logic [LEN_W-1:0]   batch_position;
	logic [CAP_W-1:0]   filled_count;

	int unsigned        idle_cycles = 0;
	bit                 hold_wanted = 1'b0;
	bit                 no_stall = 1'b0;
	slot_decision_board sb;

	sliced_reservoir_sampler dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// End the run when neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic bit [FRAC_W-1:0] draw_frac();
		bit [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return r[FRAC_W-1:0];
			default: return r[FRAC_W-1:0] >> $urandom_range(0, FRAC_W - 1);
		endcase
	endfunction

	function automatic bit [WORD_W-1:0] draw_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Offer one request after a random gap (none when no_stall is set) and hold it until accepted
	task automatic send_request(input bit [PID_W-1:0] pid, input bit [LEN_W-1:0] blen,
			input bit first, input bit [FRAC_W-1:0] frac, input bit [WORD_W-1:0] word);
		int unsigned gap;
		gap = no_stall ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		producer_id <= pid;
		batch_length <= blen;
		first_in_batch <= first;
		rand_frac <= frac;
		rand_word <= word;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(pid, blen, first, frac, word);
	endtask

	// Drain outstanding results, let the block settle, then write one register
	task automatic write_config(input reg_idx_t idx, input bit [CFG_W-1:0] value);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (CONFIG_GAP) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.write_register(idx, value);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	// Result sink: random back-pressure, one long hold on request
	initial begin : result_sink
		int unsigned gap;
		forever begin
			gap = no_stall ? 0 : $urandom_range(0, 17);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_decision(write_enable, slot_index, batch_position, filled_count);
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int unsigned     phase, count, followers, k;
		bit [CFG_W-1:0]  cap_val, thr_val;
		bit [PID_W-1:0]  pid;
		bit [LEN_W-1:0]  blen;
		bit [63:0]       tc_eff;

		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: stray element, empty batch, extremes in fill phase
		send_request(0, 5, 0, '1, '0);
		send_request(0, 0, 1, '0, '0);
		send_request(0, 5, 0, '0, '0);
		send_request(63, 16'hFFFF, 1, '1, '1);
		send_request(63, 16'hFFFF, 0, '0, '0);

		// Zero capacity and zero threads act as one
		write_config(REG_CAPACITY, 0);
		write_config(REG_THREAD_COUNT, 0);
		send_request(0, 3, 0, '0, '1);
		send_request(0, 3, 1, '0, '1);
		send_request(0, 3, 0, '1, '1);
		send_request(0, 3, 0, 1, 64'h1234_5678_9ABC_DEF0);
		send_request(0, 3, 0, 0, '1);

		// Uneven slices, last producer takes the rest; mixed and unknown producers
		write_config(REG_CAPACITY, 10);
		write_config(REG_THREAD_COUNT, 3);
		send_request(2, 4, 1, '0, '1);
		send_request(1, 4, 0, 24'h000100, 64'hFFFF_0000_FFFF_0001);
		send_request(5, 3, 1, '0, '1);
		send_request(63, 2, 1, '0, '0);

		// Out-of-range values clamp to the maximum
		write_config(REG_CAPACITY, '1);
		write_config(REG_THREAD_COUNT, 127);
		send_request(63, 4, 1, draw_frac(), draw_word());
		send_request(63, 4, 0, draw_frac(), draw_word());

		// More threads than slots: empty slices never store
		write_config(REG_CAPACITY, 2);
		write_config(REG_THREAD_COUNT, 5);
		send_request(1, 2, 1, '0, '1);
		send_request(4, 2, 1, '0, '1);
		send_request(4, 2, 0, '1, '1);
		send_request(4, 1, 1, '0, 64'h8000_0000_0000_0000);

		// Long batch crossing capacity in fill phase, back to back
		write_config(REG_CAPACITY, CFG_W'(sb.seen_total + FILL_MARGIN));
		write_config(REG_THREAD_COUNT, 1);
		no_stall = 1'b1;
		send_request(0, 16'hFFFF, 1, draw_frac(), draw_word());
		for (k = 0; k < SAT_FOLLOWERS; k++)
			send_request(0, 16'hFFFF, 0, draw_frac(), draw_word());
		no_stall = 1'b0;

		// Random phases, each under its own settings
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin cap_val = 1; thr_val = 1; end
				1: begin cap_val = MAX_SLOTS; thr_val = MAX_PRODUCERS; end
				2: begin cap_val = 0; thr_val = MAX_PRODUCERS; end
				3: begin cap_val = $urandom_range(1, 64); thr_val = $urandom_range(1, 64); end
				default: begin
					case ($urandom_range(0, 3))
						0: cap_val = $urandom_range(1, 32);
						1: cap_val = $urandom_range(1, 4096);
						2: cap_val = $urandom_range(MAX_SLOTS, (1 << CAP_W) - 1);
						default: cap_val = $urandom_range(0, 3);
					endcase
					case ($urandom_range(0, 3))
						0: thr_val = $urandom_range(1, 8);
						1: thr_val = $urandom_range(1, MAX_PRODUCERS);
						2: thr_val = $urandom_range(MAX_PRODUCERS + 1, (1 << TC_W) - 1);
						default: thr_val = 0;
					endcase
				end
			endcase
			if ($urandom_range(0, 1)) begin
				write_config(REG_CAPACITY, cap_val);
				write_config(REG_THREAD_COUNT, thr_val);
			end else begin
				write_config(REG_THREAD_COUNT, thr_val);
				write_config(REG_CAPACITY, cap_val);
			end
			no_stall = (phase % 4 == 3);
			if (phase == 2) hold_wanted = 1'b1;
			tc_eff = sb.threads_in_use();

			// Claim stream positions in bulk to reach the sampling phase
			if (phase == 1 || $urandom_range(0, 1)) begin
				while (sb.seen_total + 16'hFFFF < sb.capacity_in_use())
					send_request($urandom_range(0, 63), 16'hFFFF, 1, draw_frac(), draw_word());
			end

			count = 0;
			while (count < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					// Noise: stray elements, empty batches, raw fields
					case ($urandom_range(0, 2))
						0: send_request($urandom, $urandom, $urandom, draw_frac(), draw_word());
						1: send_request($urandom, 0, 1, draw_frac(), draw_word());
						default: send_request($urandom, $urandom, 0, draw_frac(), draw_word());
					endcase
					count++;
				end else begin
					if ($urandom_range(0, 7) == 0) begin
						pid = $urandom_range(0, 63);
					end else begin
						pid = $urandom_range(0, int'(tc_eff) - 1);
					end
					case ($urandom_range(0, 7))
						0: blen = $urandom_range(1, 65535);
						1: blen = 16'hFFFF;
						default: blen = $urandom_range(1, 10);
					endcase
					send_request(pid, blen, 1, draw_frac(), draw_word());
					followers = ((blen < 12) ? blen : 12) - 1;
					if ($urandom_range(0, 3) == 0) followers += $urandom_range(1, 2);
					for (k = 0; k < followers; k++) begin
						send_request(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : pid,
							($urandom_range(0, 15) == 0) ? $urandom : blen,
							0, draw_frac(), draw_word());
					end
					count += 1 + followers;
				end
			end
		end

		// Drain and settle
		in_valid <= 1'b0;
		no_stall = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/srs_pkg.sv
rtl/core/srs_ram.sv
rtl/core/sliced_reservoir_sampler.sv
bench/sliced_reservoir_sampler_test.sv
